// File: rtl/ltb_pkg.sv
// Shared constants, types and control structs for the line table builder.
// Used by every RTL file in this block except ltb_ram; depends on nothing else.
package ltb_pkg;

   localparam int MAX_LINES   = 1024;
   localparam int OFFSET_BITS = 24;
   localparam int LINE_BITS   = $clog2(MAX_LINES);
   localparam int COUNT_BITS  = LINE_BITS + 1;
   localparam int BYTE_BITS   = 8;
   localparam int OP_BITS     = 2;
   // one table entry: CRLF mark of the previous line above this line's start
   localparam int ENTRY_BITS  = OFFSET_BITS + 1;

   localparam logic [BYTE_BITS-1:0]   CHAR_CR    = 8'h0D;
   localparam logic [BYTE_BITS-1:0]   CHAR_LF    = 8'h0A;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH   = 2'd0,
      OP_LOCATE = 2'd1,
      OP_SPAN   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_SPAN_A,
      ST_SPAN_B
   } state_type;

   typedef enum logic [1:0] {
      RSP_PLAIN,
      RSP_LOCATE,
      RSP_SPAN
   } rsp_sel_type;

   typedef struct packed {
      logic        accept;
      logic        loc_step;
      logic        span_first;
      logic        load_rsp;
      rsp_sel_type rsp_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic search_done;
   } dp_status_type;

endpackage

// File: rtl/ltb_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on ltb_pkg for field widths.
interface ltb_req_if;
   logic                              valid;
   logic                              ready;
   logic [ltb_pkg::OP_BITS-1:0]       op;
   logic [ltb_pkg::BYTE_BITS-1:0]     in_byte;
   logic [ltb_pkg::OFFSET_BITS-1:0]   query_offset;
   logic [ltb_pkg::LINE_BITS-1:0]     query_line;

   modport source (output valid, op, in_byte, query_offset, query_line, input ready);
   modport sink   (input valid, op, in_byte, query_offset, query_line, output ready);
endinterface

interface ltb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ltb_pkg::LINE_BITS-1:0]     line_number;
   logic [ltb_pkg::OFFSET_BITS-1:0]   column;
   logic [ltb_pkg::OFFSET_BITS-1:0]   span_start;
   logic [ltb_pkg::OFFSET_BITS-1:0]   span_end;
   logic [ltb_pkg::OFFSET_BITS-1:0]   content_end;
   logic                              line_valid;
   logic [ltb_pkg::COUNT_BITS-1:0]    lines_total;
   logic                              table_full;

   modport source (output valid, line_number, column, span_start, span_end, content_end,
                   line_valid, lines_total, table_full, input ready);
   modport sink   (input valid, line_number, column, span_start, span_end, content_end,
                   line_valid, lines_total, table_full, output ready);
endinterface

// File: rtl/ltb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module ltb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/ltb_ctrl.sv
// Controller FSM: sequences pushes, binary-search lookups and span reads.
// Depends on ltb_pkg; drives the datapath through dp_cmd_type.
module ltb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  ltb_pkg::op_type        req_op,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ltb_pkg::dp_cmd_type    cmd,
   input  ltb_pkg::dp_status_type status
);

   ltb_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;

   // take a request only when idle and the response slot is free or draining
   assign req_ready = (state_ff == ltb_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ltb_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  ltb_pkg::OP_LOCATE: state_in = ltb_pkg::ST_LOCATE;
                  ltb_pkg::OP_SPAN:   state_in = ltb_pkg::ST_SPAN_A;
                  default:            state_in = ltb_pkg::ST_IDLE;
               endcase
            end
         end
         ltb_pkg::ST_LOCATE: begin
            if (status.search_done) begin
               state_in = ltb_pkg::ST_IDLE;
            end
         end
         ltb_pkg::ST_SPAN_A: state_in = ltb_pkg::ST_SPAN_B;
         ltb_pkg::ST_SPAN_B: state_in = ltb_pkg::ST_IDLE;
         default:            state_in = ltb_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '{accept: 1'b0, loc_step: 1'b0, span_first: 1'b0, load_rsp: 1'b0,
              rsp_sel: ltb_pkg::RSP_PLAIN};
      case (state_ff)
         ltb_pkg::ST_IDLE: begin
            cmd.accept = accept;
            if (accept && (req_op == ltb_pkg::OP_PUSH || req_op == ltb_pkg::OP_CLEAR)) begin
               cmd.load_rsp = 1'b1;
            end
         end
         ltb_pkg::ST_LOCATE: begin
            cmd.loc_step = 1'b1;
            cmd.rsp_sel  = ltb_pkg::RSP_LOCATE;
            cmd.load_rsp = status.search_done;
         end
         ltb_pkg::ST_SPAN_A: cmd.span_first = 1'b1;
         ltb_pkg::ST_SPAN_B: begin
            cmd.rsp_sel  = ltb_pkg::RSP_SPAN;
            cmd.load_rsp = 1'b1;
         end
         default: cmd.accept = 1'b0;
      endcase
   end

   // response valid: set on load, cleared when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ltb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/ltb_datapath.sv
// Datapath: line table RAM, counters, binary-search registers, response payload.
// Depends on ltb_pkg and ltb_ram; controlled by ltb_ctrl.
module ltb_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ltb_pkg::dp_cmd_type                cmd,
   output ltb_pkg::dp_status_type             status,
   input  ltb_pkg::op_type                    req_op,
   input  logic [ltb_pkg::BYTE_BITS-1:0]      req_in_byte,
   input  logic [ltb_pkg::OFFSET_BITS-1:0]    req_query_offset,
   input  logic [ltb_pkg::LINE_BITS-1:0]      req_query_line,
   output logic [ltb_pkg::LINE_BITS-1:0]      rsp_line_number,
   output logic [ltb_pkg::OFFSET_BITS-1:0]    rsp_column,
   output logic [ltb_pkg::OFFSET_BITS-1:0]    rsp_span_start,
   output logic [ltb_pkg::OFFSET_BITS-1:0]    rsp_span_end,
   output logic [ltb_pkg::OFFSET_BITS-1:0]    rsp_content_end,
   output logic                               rsp_line_valid,
   output logic [ltb_pkg::COUNT_BITS-1:0]     rsp_lines_total,
   output logic                               rsp_table_full
);

   // table state
   logic [ltb_pkg::OFFSET_BITS-1:0] byte_count_ff, byte_count_in;
   logic [ltb_pkg::COUNT_BITS-1:0]  line_count_ff, line_count_in;
   logic                            pending_cr_ff, pending_cr_in;
   logic                            overflow_ff, overflow_in;

   // query registers
   logic [ltb_pkg::OFFSET_BITS-1:0] qoff_ff, qoff_in;
   logic [ltb_pkg::LINE_BITS-1:0]   qline_ff, qline_in;
   logic [ltb_pkg::COUNT_BITS-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [ltb_pkg::LINE_BITS-1:0]   mid_ff, mid_in;
   logic [ltb_pkg::OFFSET_BITS-1:0] lo_start_ff, lo_start_in;
   logic [ltb_pkg::OFFSET_BITS-1:0] span_start_ff, span_start_in;

   // response payload
   logic [ltb_pkg::LINE_BITS-1:0]   line_number_ff, line_number_in;
   logic [ltb_pkg::OFFSET_BITS-1:0] column_ff, column_in;
   logic [ltb_pkg::OFFSET_BITS-1:0] span_start_out_ff, span_start_out_in;
   logic [ltb_pkg::OFFSET_BITS-1:0] span_end_ff, span_end_in;
   logic [ltb_pkg::OFFSET_BITS-1:0] content_end_ff, content_end_in;
   logic                            line_valid_ff, line_valid_in;
   logic [ltb_pkg::COUNT_BITS-1:0]  lines_total_ff, lines_total_in;
   logic                            table_full_ff, table_full_in;

   // RAM port signals
   logic                            ram_we;
   logic [ltb_pkg::LINE_BITS-1:0]   ram_waddr, ram_raddr;
   logic [ltb_pkg::ENTRY_BITS-1:0]  ram_wdata, ram_rdata;
   logic [ltb_pkg::OFFSET_BITS-1:0] rd_start;
   logic                            rd_crlf;

   // search step
   logic [ltb_pkg::COUNT_BITS-1:0]  search_len, lo_step, hi_step, mid_step;
   logic                            take_lo;

   // span decode
   logic                            span_valid, span_last;

   logic                            is_push, is_clear, is_locate;
   logic [ltb_pkg::OFFSET_BITS-1:0] byte_next;

   // entry k holds the start of line k and the CRLF mark of line k-1
   ltb_ram #(
      .WIDTH (ltb_pkg::ENTRY_BITS),
      .DEPTH (ltb_pkg::MAX_LINES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_start = ram_rdata[ltb_pkg::OFFSET_BITS-1:0];
   assign rd_crlf  = ram_rdata[ltb_pkg::OFFSET_BITS];

   assign is_push   = cmd.accept && (req_op == ltb_pkg::OP_PUSH);
   assign is_clear  = cmd.accept && (req_op == ltb_pkg::OP_CLEAR);
   assign is_locate = cmd.accept && (req_op == ltb_pkg::OP_LOCATE);
   assign byte_next = byte_count_ff + 1'b1;

   // byte push and clear
   always_comb begin
      byte_count_in = byte_count_ff;
      line_count_in = line_count_ff;
      pending_cr_in = pending_cr_ff;
      overflow_in   = overflow_ff;
      ram_we        = 1'b0;
      ram_waddr     = line_count_ff[ltb_pkg::LINE_BITS-1:0];
      ram_wdata     = {pending_cr_ff, byte_next};
      if (is_clear) begin
         byte_count_in = '0;
         line_count_in = ltb_pkg::COUNT_BITS'(1);
         pending_cr_in = 1'b0;
         overflow_in   = 1'b0;
      end else if (is_push && (byte_count_ff != ltb_pkg::OFFSET_MAX)) begin
         byte_count_in = byte_next;
         pending_cr_in = (req_in_byte == ltb_pkg::CHAR_CR);
         if (req_in_byte == ltb_pkg::CHAR_LF) begin
            if (line_count_ff < ltb_pkg::COUNT_BITS'(ltb_pkg::MAX_LINES)) begin
               ram_we        = 1'b1;
               line_count_in = line_count_ff + 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
         end
      end
   end

   // one halving of [lo, hi) per cycle, next probe issued in the same cycle
   assign search_len         = hi_ff - lo_ff;
   assign status.search_done = (search_len < ltb_pkg::COUNT_BITS'(2));
   assign take_lo            = (rd_start <= qoff_ff);
   assign lo_step            = take_lo ? {1'b0, mid_ff} : lo_ff;
   assign hi_step            = take_lo ? hi_ff : {1'b0, mid_ff};
   assign mid_step           = lo_step + ((hi_step - lo_step) >> 1);

   // query registers and read address
   always_comb begin
      qoff_in       = qoff_ff;
      qline_in      = qline_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      lo_start_in   = lo_start_ff;
      span_start_in = span_start_ff;
      ram_raddr     = mid_step[ltb_pkg::LINE_BITS-1:0];
      if (cmd.accept) begin
         qoff_in     = req_query_offset;
         qline_in    = req_query_line;
         lo_in       = '0;
         hi_in       = line_count_ff;
         lo_start_in = '0;
         mid_in      = line_count_ff[ltb_pkg::COUNT_BITS-1:1];
         ram_raddr   = is_locate ? line_count_ff[ltb_pkg::COUNT_BITS-1:1] : req_query_line;
      end else if (cmd.span_first) begin
         ram_raddr     = qline_ff + 1'b1;
         // line 0 always starts at offset zero
         span_start_in = (qline_ff == '0) ? '0 : rd_start;
      end else if (cmd.loc_step && !status.search_done) begin
         lo_in       = lo_step;
         hi_in       = hi_step;
         mid_in      = mid_step[ltb_pkg::LINE_BITS-1:0];
         lo_start_in = take_lo ? rd_start : lo_start_ff;
      end
   end

   assign span_valid = ({1'b0, qline_ff} < line_count_ff);
   assign span_last  = ({1'b0, qline_ff} == (line_count_ff - 1'b1));

   // response payload
   always_comb begin
      line_number_in    = line_number_ff;
      column_in         = column_ff;
      span_start_out_in = span_start_out_ff;
      span_end_in       = span_end_ff;
      content_end_in    = content_end_ff;
      line_valid_in     = line_valid_ff;
      lines_total_in    = lines_total_ff;
      table_full_in     = table_full_ff;
      if (cmd.load_rsp) begin
         line_number_in    = '0;
         column_in         = '0;
         span_start_out_in = '0;
         span_end_in       = '0;
         content_end_in    = '0;
         line_valid_in     = 1'b0;
         lines_total_in    = line_count_in;
         table_full_in     = overflow_in;
         case (cmd.rsp_sel)
            ltb_pkg::RSP_LOCATE: begin
               line_number_in = lo_ff[ltb_pkg::LINE_BITS-1:0];
               column_in      = qoff_ff - lo_start_ff;
            end
            ltb_pkg::RSP_SPAN: begin
               if (span_valid) begin
                  line_valid_in     = 1'b1;
                  span_start_out_in = span_start_ff;
                  if (span_last) begin
                     span_end_in    = byte_count_ff;
                     content_end_in = byte_count_ff;
                  end else begin
                     span_end_in    = rd_start;
                     content_end_in = rd_start - ltb_pkg::OFFSET_BITS'(1)
                                      - ltb_pkg::OFFSET_BITS'(rd_crlf);
                  end
               end
            end
            default: line_valid_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         line_count_ff <= ltb_pkg::COUNT_BITS'(1);
         pending_cr_ff <= 1'b0;
         overflow_ff   <= 1'b0;
         lo_ff         <= '0;
         hi_ff         <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         line_count_ff <= line_count_in;
         pending_cr_ff <= pending_cr_in;
         overflow_ff   <= overflow_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      qoff_ff           <= qoff_in;
      qline_ff          <= qline_in;
      mid_ff            <= mid_in;
      lo_start_ff       <= lo_start_in;
      span_start_ff     <= span_start_in;
      line_number_ff    <= line_number_in;
      column_ff         <= column_in;
      span_start_out_ff <= span_start_out_in;
      span_end_ff       <= span_end_in;
      content_end_ff    <= content_end_in;
      line_valid_ff     <= line_valid_in;
      lines_total_ff    <= lines_total_in;
      table_full_ff     <= table_full_in;
   end

   assign rsp_line_number = line_number_ff;
   assign rsp_column      = column_ff;
   assign rsp_span_start  = span_start_out_ff;
   assign rsp_span_end    = span_end_ff;
   assign rsp_content_end = content_end_ff;
   assign rsp_line_valid  = line_valid_ff;
   assign rsp_lines_total = lines_total_ff;
   assign rsp_table_full  = table_full_ff;

endmodule

// File: rtl/line_table_builder_and_locator.sv
// Top level of the line table builder and locator.
// Depends on ltb_pkg, ltb_if, ltb_ctrl and ltb_datapath.
//
//  Channel | Dir | Handshake        | Payload
//  --------+-----+------------------+------------------------------------------------
//  req     | in  | req.valid/ready  | op, in_byte, query_offset, query_line
//  rsp     | out | rsp.valid/ready  | line_number, column, span_start, span_end,
//          |     |                  | content_end, line_valid, lines_total, table_full
//
// Push and clear load their response on accept; a span lookup steps through
// ST_SPAN_A and ST_SPAN_B; locate runs a binary search over the table, one
// table probe per cycle through the single read port of the line table RAM.
// One request is in flight at a time; a new one is taken while the previous
// response waits in the output register, as long as that register drains.
// Synchronous reset; the table RAM is not cleared (line 0 starts at zero by
// construction and other entries are read only after they are written).
module line_table_builder_and_locator (
   input logic      clock,
   input logic      reset,
   ltb_req_if.sink  req,
   ltb_rsp_if.source rsp
);

   ltb_pkg::dp_cmd_type    cmd;
   ltb_pkg::dp_status_type status;

   ltb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (ltb_pkg::op_type'(req.op)),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   ltb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (ltb_pkg::op_type'(req.op)),
      .req_in_byte      (req.in_byte),
      .req_query_offset (req.query_offset),
      .req_query_line   (req.query_line),
      .rsp_line_number  (rsp.line_number),
      .rsp_column       (rsp.column),
      .rsp_span_start   (rsp.span_start),
      .rsp_span_end     (rsp.span_end),
      .rsp_content_end  (rsp.content_end),
      .rsp_line_valid   (rsp.line_valid),
      .rsp_lines_total  (rsp.lines_total),
      .rsp_table_full   (rsp.table_full)
   );

endmodule

// File: tb/tb_line_table_builder_and_locator.sv
// Self-checking testbench for line_table_builder_and_locator: drives push, locate, span and
// clear beats over the request channel and compares every response with a behavioral model.
// Depends on ltb_pkg, the ltb_req_if/ltb_rsp_if interfaces and the block's RTL.
module tb_line_table_builder_and_locator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 400_000;
   localparam int unsigned DRAIN_CYCLES = 24;
   localparam int unsigned MAX_GAP      = 40;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef struct packed {
      ltb_pkg::op_type                 op;
      logic [ltb_pkg::BYTE_BITS-1:0]   in_byte;
      logic [ltb_pkg::OFFSET_BITS-1:0] query_offset;
      logic [ltb_pkg::LINE_BITS-1:0]   query_line;
   } line_request_type;

   typedef struct packed {
      logic [ltb_pkg::LINE_BITS-1:0]   line_number;
      logic [ltb_pkg::OFFSET_BITS-1:0] column;
      logic [ltb_pkg::OFFSET_BITS-1:0] span_start;
      logic [ltb_pkg::OFFSET_BITS-1:0] span_end;
      logic [ltb_pkg::OFFSET_BITS-1:0] content_end;
      logic                            line_valid;
      logic [ltb_pkg::COUNT_BITS-1:0]  lines_total;
      logic                            table_full;
   } line_result_type;

   // Tracks the line table as the block should see it and holds the responses still owed.
   class line_table_scoreboard_type;
      logic [ltb_pkg::OFFSET_BITS-1:0] starts [ltb_pkg::MAX_LINES];
      bit                              crlf_after [ltb_pkg::MAX_LINES];
      int unsigned                     n_lines;
      logic [ltb_pkg::OFFSET_BITS-1:0] content_len;
      bit                              last_was_cr;
      bit                              dropped_line;
      line_result_type                 expected_q [$];
      int unsigned                     failures;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         n_lines      = 1;
         content_len  = '0;
         last_was_cr  = 1'b0;
         dropped_line = 1'b0;
         starts[0]    = '0;
      endfunction

      function string describe(line_result_type r);
         return {$sformatf("line=%0d col=%0d start=%0d end=%0d ",
                           r.line_number, r.column, r.span_start, r.span_end),
                 $sformatf("cend=%0d valid=%0b total=%0d full=%0b",
                           r.content_end, r.line_valid, r.lines_total, r.table_full)};
      endfunction

      function void flag_failure(string msg);
         failures++;
         if (failures <= MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
         end
      endfunction

      // Applies one accepted beat to the table and queues the response it must produce.
      function void note_request(line_request_type rq);
         line_result_type r;
         int              idx;
         r = '0;
         case (rq.op)
            ltb_pkg::OP_PUSH: begin
               // a saturated content length swallows the byte without any effect
               if (content_len != ltb_pkg::OFFSET_MAX) begin
                  content_len++;
                  if (rq.in_byte == ltb_pkg::CHAR_LF) begin
                     crlf_after[n_lines-1] = last_was_cr;
                     if (n_lines < ltb_pkg::MAX_LINES) begin
                        starts[n_lines] = content_len;
                        n_lines++;
                     end else begin
                        dropped_line = 1'b1;
                     end
                  end
                  last_was_cr = (rq.in_byte == ltb_pkg::CHAR_CR);
               end
            end
            ltb_pkg::OP_LOCATE: begin
               // starts are strictly increasing, so scan down for the last one not above
               idx = n_lines - 1;
               while (starts[idx] > rq.query_offset) idx--;
               r.line_number = ltb_pkg::LINE_BITS'(idx);
               r.column      = rq.query_offset - starts[idx];
            end
            ltb_pkg::OP_SPAN: begin
               if (rq.query_line < n_lines) begin
                  r.line_valid = 1'b1;
                  r.span_start = starts[rq.query_line];
                  if (rq.query_line == n_lines - 1) begin
                     r.span_end    = content_len;
                     r.content_end = content_len;
                  end else begin
                     r.span_end    = starts[rq.query_line + 10'd1];
                     r.content_end = r.span_end - ltb_pkg::OFFSET_BITS'(1)
                                     - ltb_pkg::OFFSET_BITS'(crlf_after[rq.query_line]);
                  end
               end
            end
            ltb_pkg::OP_CLEAR: begin
               restart();
            end
            default: ;
         endcase
         r.lines_total = ltb_pkg::COUNT_BITS'(n_lines);
         r.table_full  = dropped_line;
         expected_q.push_back(r);
      endfunction

      function void check_result(line_result_type got);
         line_result_type exp;
         if (expected_q.size() == 0) begin
            flag_failure($sformatf("response with none outstanding: %s", describe(got)));
            return;
         end
         exp = expected_q.pop_front();
         if (got !== exp) begin
            flag_failure($sformatf("response mismatch\n   expected %s\n   actual   %s",
                                   describe(exp), describe(got)));
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   int unsigned               cycle_count = 0;
   int unsigned               idle_pct = 0;
   int unsigned               stall_pct = 0;
   line_table_scoreboard_type sb;

   ltb_req_if req_ch ();
   ltb_rsp_if rsp_ch ();

   line_table_builder_and_locator i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_line_table_builder_and_locator: FAIL");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      line_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.line_number, rsp_ch.column, rsp_ch.span_start, rsp_ch.span_end,
                rsp_ch.content_end, rsp_ch.line_valid, rsp_ch.lines_total, rsp_ch.table_full};
         sb.check_result(got);
      end
   end

   function automatic line_request_type make_request(ltb_pkg::op_type op,
                                                     logic [ltb_pkg::BYTE_BITS-1:0] b,
                                                     logic [ltb_pkg::OFFSET_BITS-1:0] off,
                                                     logic [ltb_pkg::LINE_BITS-1:0] ln);
      line_request_type rq;
      rq.op           = op;
      rq.in_byte      = b;
      rq.query_offset = off;
      rq.query_line   = ln;
      return rq;
   endfunction

   // push beat: LF with the given weight, CR one time in ten, otherwise any byte
   function automatic line_request_type push_request(int unsigned lf_pct);
      line_request_type rq;
      int unsigned      k;
      rq.op           = ltb_pkg::OP_PUSH;
      rq.in_byte      = ltb_pkg::BYTE_BITS'($urandom_range(255));
      rq.query_offset = ltb_pkg::OFFSET_BITS'($urandom);
      rq.query_line   = ltb_pkg::LINE_BITS'($urandom);
      k = $urandom_range(99);
      if (k < lf_pct) begin
         rq.in_byte = ltb_pkg::CHAR_LF;
      end else if (k < lf_pct + 10) begin
         rq.in_byte = ltb_pkg::CHAR_CR;
      end
      return rq;
   endfunction

   // mostly text with queries aimed at real lines and offsets, some out of range, rare clears
   function automatic line_request_type random_request();
      line_request_type rq;
      int unsigned      pick;
      int unsigned      ln;
      rq   = push_request(20);
      pick = $urandom_range(99);
      ln   = $urandom_range(sb.n_lines - 1);
      if (pick >= 55 && pick < 77) begin
         rq.op = ltb_pkg::OP_LOCATE;
         case ($urandom_range(4))
            0: rq.query_offset = ltb_pkg::OFFSET_BITS'($urandom);
            1, 2: rq.query_offset = ltb_pkg::OFFSET_BITS'($urandom_range(sb.content_len + 2));
            3: rq.query_offset = sb.starts[ln];
            4: rq.query_offset = sb.starts[ln] - ltb_pkg::OFFSET_BITS'(1);
            default: ;
         endcase
      end else if (pick >= 77 && pick < 99) begin
         rq.op = ltb_pkg::OP_SPAN;
         case ($urandom_range(4))
            0, 1, 2: rq.query_line = ltb_pkg::LINE_BITS'(ln);
            3: rq.query_line = ltb_pkg::LINE_BITS'(sb.n_lines);
            default: ;
         endcase
      end else if (pick == 99) begin
         rq.op = ltb_pkg::OP_CLEAR;
      end
      return rq;
   endfunction

   // offers one beat after a random idle gap and records it once accepted
   task automatic send_request(line_request_type rq);
      int unsigned gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= rq.op;
      req_ch.in_byte      <= rq.in_byte;
      req_ch.query_offset <= rq.query_offset;
      req_ch.query_line   <= rq.query_line;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(rq);
   endtask

   // holds the sender off until every owed response has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   initial begin
      int unsigned idle_by_phase [4];
      int unsigned stall_by_phase [4];
      sb = new();
      idle_by_phase  = '{0, 68, 0, 16};
      stall_by_phase = '{0, 0, 68, 16};
      req_ch.valid        <= 1'b0;
      req_ch.op           <= ltb_pkg::OP_PUSH;
      req_ch.in_byte      <= '0;
      req_ch.query_offset <= '0;
      req_ch.query_line   <= '0;
      reset               <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, CRLF vs lone CR, CR CR LF, empty line, past-end lookups, clear
      send_request(make_request(ltb_pkg::OP_SPAN, 8'h00, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_LOCATE, 8'hFF, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_LOCATE, 8'h00, ltb_pkg::OFFSET_MAX, 10'h3FF));
      send_request(make_request(ltb_pkg::OP_SPAN, 8'h00, '0, 10'd1));
      send_request(make_request(ltb_pkg::OP_SPAN, 8'h00, '0, 10'h3FF));
      send_request(make_request(ltb_pkg::OP_PUSH, 8'h61, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_PUSH, ltb_pkg::CHAR_CR, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_PUSH, ltb_pkg::CHAR_LF, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_PUSH, ltb_pkg::CHAR_CR, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_PUSH, 8'hFF, ltb_pkg::OFFSET_MAX, 10'h3FF));
      send_request(make_request(ltb_pkg::OP_PUSH, ltb_pkg::CHAR_LF, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_PUSH, 8'h00, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_PUSH, ltb_pkg::CHAR_CR, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_PUSH, ltb_pkg::CHAR_CR, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_PUSH, ltb_pkg::CHAR_LF, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_PUSH, ltb_pkg::CHAR_LF, '0, 10'd0));
      for (int ln = 0; ln <= 5; ln++) begin
         send_request(make_request(ltb_pkg::OP_SPAN, 8'h00, '0, ltb_pkg::LINE_BITS'(ln)));
      end
      send_request(make_request(ltb_pkg::OP_LOCATE, 8'h00, 24'd3, 10'd0));
      send_request(make_request(ltb_pkg::OP_LOCATE, 8'h00, 24'd9, 10'd0));
      send_request(make_request(ltb_pkg::OP_LOCATE, 8'h00, 24'd11, 10'd0));
      send_request(make_request(ltb_pkg::OP_CLEAR, 8'h00, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_SPAN, 8'h00, '0, 10'd0));
      send_request(make_request(ltb_pkg::OP_LOCATE, 8'h00, 24'd5, 10'd0));
      wait_drained();

      // random traffic under each idling pattern, draining between patterns
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_by_phase[ph];
         stall_pct = stall_by_phase[ph];
         repeat (140) send_request(random_request());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         sb.flag_failure($sformatf("%0d responses never arrived", sb.expected_q.size()));
      end
      if (sb.failures == 0) begin
         $display("tb_line_table_builder_and_locator: PASS");
      end else begin
         $display("tb_line_table_builder_and_locator: FAIL");
      end
      $finish;
   end

endmodule
